@@ src/lab_pkg.sv @@
// ----------------------------------------------------------------------------
// lab_pkg: shared types and constants for the line resampler
// Field widths, command and register codes, and pixel word helpers.
// ----------------------------------------------------------------------------
package lab_pkg;

    localparam int LEN_W        = 13;   // in_len / out_len register width
    localparam int IDX_W        = 12;   // pixel position width
    localparam int CH_W         = 8;    // one channel value
    localparam int NUM_CH       = 4;    // channel lanes on the ports
    localparam int NCH_W        = 3;    // channel count register width
    localparam int CFG_IDX_W    = 2;    // configuration register index
    localparam int CFG_DATA_W   = 13;   // configuration write data
    localparam int MAX_LINE_DEF = 4096;
    localparam int MAX_CHANNELS = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

    // command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    typedef logic [NUM_CH*CH_W-1:0] word_t;
    typedef logic [CH_W-1:0]        chan_t;

    // Pick one channel byte out of a stored pixel word.
    function automatic chan_t chan_byte(input word_t w, input logic [1:0] c);
        chan_t b;
        unique case (c)
            2'd0: b = w[7:0];
            2'd1: b = w[15:8];
            2'd2: b = w[23:16];
            default: b = w[31:24];
        endcase
        return b;
    endfunction

endpackage

@@ src/lab_if.sv @@
// ----------------------------------------------------------------------------
// lab_if: channel interfaces for the line resampler
// Configuration write, command input and pixel result channels.
// ----------------------------------------------------------------------------
interface lab_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lab_pkg::CFG_IDX_W-1:0]    index;
    logic [lab_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface lab_in_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [lab_pkg::IDX_W-1:0]    index;
    logic [lab_pkg::CH_W-1:0]     in_chan0;
    logic [lab_pkg::CH_W-1:0]     in_chan1;
    logic [lab_pkg::CH_W-1:0]     in_chan2;
    logic [lab_pkg::CH_W-1:0]     in_chan3;

    modport source (output valid, cmd, index, in_chan0, in_chan1, in_chan2, in_chan3,
                    input ready);
    modport sink   (input valid, cmd, index, in_chan0, in_chan1, in_chan2, in_chan3,
                    output ready);
endinterface

interface lab_out_if;
    logic                         valid;
    logic                         ready;
    logic [lab_pkg::IDX_W-1:0]    result_index;
    logic [lab_pkg::CH_W-1:0]     out_chan0;
    logic [lab_pkg::CH_W-1:0]     out_chan1;
    logic [lab_pkg::CH_W-1:0]     out_chan2;
    logic [lab_pkg::CH_W-1:0]     out_chan3;

    modport source (output valid, result_index, out_chan0, out_chan1, out_chan2, out_chan3,
                    input ready);
    modport sink   (input valid, result_index, out_chan0, out_chan1, out_chan2, out_chan3,
                    output ready);
endinterface

@@ src/lab_div.sv @@
// ----------------------------------------------------------------------------
// lab_div: shared restoring divider
// One quotient bit per cycle; done is a one-cycle pulse after the last quotient bit.
// ----------------------------------------------------------------------------
module lab_div #(
    parameter int W = 26
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quo,
    output logic [W-1:0] rem
);

    localparam int CW = $clog2(W + 1);

    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    // step one quotient bit
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[W-1:0], quo_reg[W-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= den_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg[W-1:0];

endmodule

@@ src/line_area_bilinear_resampler.sv @@
// ----------------------------------------------------------------------------
// line_area_bilinear_resampler: one-line box-average / bilinear resizer
// Stores a line of pixels and computes one resampled pixel per request.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | moves on
//  cfg     | in  | index, data                               | valid & ready
//  req     | in  | cmd, index, in_chan0..3                   | valid & ready
//  rsp     | out | result_index, out_chan0..3                | valid & ready
//
//  A request runs on a sequencer around one shared divider of W = XW+13
//  bits: a copy reads one stored word; an enlarge does at most one divide
//  for the pixel center and one per channel; a shrink does two divides for
//  its source span, weights each source pixel, then one divide per channel.
//  Reset clears control and sets in_len = out_len = 1, channels = 4; the line
//  store is not cleared. req is held off while a request runs; a finished
//  word waits in the rsp register and loads are still taken meanwhile.
// ----------------------------------------------------------------------------
module line_area_bilinear_resampler #(
    parameter int MAX_LINE = lab_pkg::MAX_LINE_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lab_cfg_if.sink   cfg,
    lab_in_if.sink    req,
    lab_out_if.source rsp
);

    localparam int AW   = (MAX_LINE > 2) ? $clog2(MAX_LINE) : 1;
    localparam int LW   = $clog2(MAX_LINE + 1);
    localparam int XW   = (LW > lab_pkg::LEN_W) ? LW : lab_pkg::LEN_W;
    localparam int PRW  = XW + lab_pkg::IDX_W + 1;
    localparam int ACCW = XW + lab_pkg::CH_W + 1;
    localparam int TW   = XW + 1;
    localparam int DW   = XW + 2;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_COPY_RD  = 5'd1;
    localparam logic [4:0] S_COPY_GET = 5'd2;
    localparam logic [4:0] S_DN_MUL   = 5'd3;
    localparam logic [4:0] S_DN_X0    = 5'd4;
    localparam logic [4:0] S_DN_X0W   = 5'd5;
    localparam logic [4:0] S_DN_X1    = 5'd6;
    localparam logic [4:0] S_DN_X1W   = 5'd7;
    localparam logic [4:0] S_DN_LO    = 5'd8;
    localparam logic [4:0] S_DN_RD    = 5'd9;
    localparam logic [4:0] S_DN_ACC   = 5'd10;
    localparam logic [4:0] S_DN_END   = 5'd11;
    localparam logic [4:0] S_UP_MUL   = 5'd12;
    localparam logic [4:0] S_UP_CTR   = 5'd13;
    localparam logic [4:0] S_UP_W     = 5'd14;
    localparam logic [4:0] S_UP_CLAMP = 5'd15;
    localparam logic [4:0] S_UP_RD0   = 5'd16;
    localparam logic [4:0] S_UP_RD1   = 5'd17;
    localparam logic [4:0] S_UP_GOT1  = 5'd18;
    localparam logic [4:0] S_CH_MUL   = 5'd19;
    localparam logic [4:0] S_CH_DIV   = 5'd20;
    localparam logic [4:0] S_CH_W     = 5'd21;
    localparam logic [4:0] S_FINISH   = 5'd22;

    // configuration
    logic [lab_pkg::LEN_W-1:0] in_len_reg, in_len_next;
    logic [lab_pkg::LEN_W-1:0] out_len_reg, out_len_next;
    logic [lab_pkg::NCH_W-1:0] chans_reg, chans_next;

    // sequencer and working registers
    logic [4:0]                state_reg, state_next;
    logic [lab_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [XW-1:0]             n_reg, n_next, m_reg, m_next;
    logic [lab_pkg::NCH_W-1:0] nch_reg, nch_next;
    logic                      up_reg, up_next;
    logic [PRW-1:0]            start_reg, start_next, end_reg, end_next;
    logic [PRW-1:0]            lo_reg, lo_next;
    logic [XW-1:0]             x_reg, x_next, x0_reg, x0_next, x1_reg, x1_next;
    logic [DW-1:0]             f_reg, f_next;
    logic [TW-1:0]             tot_reg, tot_next;
    logic [ACCW-1:0]           acc_reg [lab_pkg::NUM_CH];
    logic [ACCW-1:0]           acc_next [lab_pkg::NUM_CH];
    lab_pkg::word_t            w0_reg, w0_next, w1_reg, w1_next;
    logic [PRW-1:0]            num_reg, num_next;
    logic [DW-1:0]             den_reg, den_next;
    logic [1:0]                ch_reg, ch_next;
    logic [lab_pkg::CH_W-1:0]  res_reg [lab_pkg::NUM_CH];
    logic [lab_pkg::CH_W-1:0]  res_next [lab_pkg::NUM_CH];

    // result register
    logic                      ovalid_reg, ovalid_next;
    logic [lab_pkg::IDX_W-1:0] oidx_reg, oidx_next;
    logic [lab_pkg::CH_W-1:0]  ochan_reg [lab_pkg::NUM_CH];
    logic [lab_pkg::CH_W-1:0]  ochan_next [lab_pkg::NUM_CH];

    // line store
    lab_pkg::word_t mem [MAX_LINE];
    lab_pkg::word_t rdata_reg;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    lab_pkg::word_t wr_word;

    // divider hookup
    logic           div_start, div_done;
    logic [PRW-1:0] div_num, div_den, div_quo, div_rem;

    logic [XW-1:0]             n_cur, m_cur;
    logic [lab_pkg::NCH_W-1:0] nch_cur;
    logic                      in_acc, out_acc;
    logic [PRW-1:0]            hi, hic, loc, prod;
    logic [XW-1:0]             w_cur;
    logic [XW:0]               x_inc;
    lab_pkg::chan_t            b0, b1;

    lab_div #(.W(PRW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign in_acc    = req.valid && req.ready;
    assign out_acc   = rsp.valid && rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // clamp lengths and channel count
    always_comb
    begin
        if (in_len_reg == '0)
            n_cur = XW'(1);
        else if (XW'(in_len_reg) > XW'(MAX_LINE))
            n_cur = XW'(MAX_LINE);
        else
            n_cur = XW'(in_len_reg);
        if (out_len_reg == '0)
            m_cur = XW'(1);
        else if (XW'(out_len_reg) > XW'(MAX_LINE))
            m_cur = XW'(MAX_LINE);
        else
            m_cur = XW'(out_len_reg);
        if (chans_reg == '0)
            nch_cur = lab_pkg::NCH_W'(1);
        else if (chans_reg > lab_pkg::NCH_W'(lab_pkg::MAX_CHANNELS))
            nch_cur = lab_pkg::NCH_W'(lab_pkg::MAX_CHANNELS);
        else
            nch_cur = chans_reg;
    end

    // take configuration writes
    always_comb
    begin
        in_len_next  = in_len_reg;
        out_len_next = out_len_reg;
        chans_next   = chans_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                lab_pkg::REG_IN_LEN:   in_len_next  = cfg.data;
                lab_pkg::REG_OUT_LEN:  out_len_next = cfg.data;
                lab_pkg::REG_CHANNELS: chans_next   = cfg.data[lab_pkg::NCH_W-1:0];
                default: ;
            endcase
        end
    end

    // window overlap of the current source pixel
    always_comb
    begin
        hi    = lo_reg + PRW'(m_reg);
        hic   = (hi > end_reg) ? end_reg : hi;
        loc   = (lo_reg < start_reg) ? start_reg : lo_reg;
        w_cur = (hic > loc) ? XW'(hic - loc) : '0;
        x_inc = {1'b0, x_reg} + (XW+1)'(1);
        b0    = lab_pkg::chan_byte(w0_reg, ch_reg);
        b1    = lab_pkg::chan_byte(w1_reg, ch_reg);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        nch_next   = nch_reg;
        up_next    = up_reg;
        start_next = start_reg;
        end_next   = end_reg;
        lo_next    = lo_reg;
        x_next     = x_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        f_next     = f_reg;
        tot_next   = tot_reg;
        w0_next    = w0_reg;
        w1_next    = w1_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        ch_next    = ch_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        ovalid_next = ovalid_reg;
        oidx_next   = oidx_reg;
        ochan_next  = ochan_reg;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        rd_addr    = x_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_word    = {req.in_chan3, req.in_chan2, req.in_chan1, req.in_chan0};
        prod       = '0;

        if (out_acc)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && req.cmd == lab_pkg::CMD_LOAD)
                begin
                    wr_en = (32'(req.index) < MAX_LINE);
                end
                else if (in_acc)
                begin
                    idx_next = req.index;
                    n_next   = n_cur;
                    m_next   = m_cur;
                    nch_next = nch_cur;
                    up_next  = (m_cur > n_cur);
                    tot_next = '0;
                    ch_next  = '0;
                    for (int c = 0; c < lab_pkg::NUM_CH; c++)
                    begin
                        acc_next[c] = '0;
                        res_next[c] = '0;
                    end
                    if (m_cur == n_cur)
                    begin
                        x_next = (XW'(req.index) > n_cur - XW'(1)) ? n_cur - XW'(1)
                                                                   : XW'(req.index);
                        state_next = S_COPY_RD;
                    end
                    else if (m_cur < n_cur)
                        state_next = S_DN_MUL;
                    else
                        state_next = S_UP_MUL;
                end
            end

            S_COPY_RD:
                state_next = S_COPY_GET;

            S_COPY_GET:
            begin
                for (int c = 0; c < lab_pkg::NUM_CH; c++)
                    res_next[c] = (lab_pkg::NCH_W'(c) < nch_reg)
                                  ? lab_pkg::chan_byte(rdata_reg, 2'(c)) : '0;
                state_next = S_FINISH;
            end

            // shrink: find the source span of this output pixel
            S_DN_MUL:
            begin
                prod       = PRW'(idx_reg) * PRW'(n_reg);
                start_next = prod;
                end_next   = prod + PRW'(n_reg);
                state_next = S_DN_X0;
            end

            S_DN_X0:
            begin
                div_start  = 1'b1;
                div_num    = start_reg;
                div_den    = PRW'(m_reg);
                state_next = S_DN_X0W;
            end

            S_DN_X0W:
            begin
                if (div_done)
                begin
                    x0_next = (div_quo > PRW'(n_reg - XW'(1))) ? n_reg - XW'(1)
                                                                : XW'(div_quo);
                    state_next = S_DN_X1;
                end
            end

            S_DN_X1:
            begin
                div_start  = 1'b1;
                div_num    = end_reg + PRW'(m_reg) - PRW'(1);
                div_den    = PRW'(m_reg);
                state_next = S_DN_X1W;
            end

            S_DN_X1W:
            begin
                if (div_done)
                begin
                    x1_next = (div_quo > PRW'(n_reg)) ? n_reg : XW'(div_quo);
                    state_next = S_DN_LO;
                end
            end

            S_DN_LO:
            begin
                lo_next    = PRW'(x0_reg) * PRW'(m_reg);
                x_next     = x0_reg;
                state_next = (x0_reg >= x1_reg) ? S_DN_END : S_DN_RD;
            end

            S_DN_RD:
                state_next = S_DN_ACC;

            // accumulate one source pixel weighted by its overlap
            S_DN_ACC:
            begin
                tot_next = tot_reg + TW'(w_cur);
                for (int c = 0; c < lab_pkg::NUM_CH; c++)
                    acc_next[c] = acc_reg[c]
                                + ACCW'(lab_pkg::chan_byte(rdata_reg, 2'(c))) * ACCW'(w_cur);
                x_next  = x_inc[XW-1:0];
                lo_next = hi;
                state_next = (x_inc >= {1'b0, x1_reg}) ? S_DN_END : S_DN_RD;
            end

            S_DN_END:
            begin
                if (tot_reg == '0)
                begin
                    x_next     = x0_reg;
                    state_next = S_COPY_RD;
                end
                else
                begin
                    den_next   = DW'(tot_reg);
                    state_next = S_CH_MUL;
                end
            end

            // enlarge: locate the pixel center in units of 1/(2m)
            S_UP_MUL:
            begin
                prod       = PRW'({idx_reg, 1'b1}) * PRW'(n_reg);
                start_next = prod;
                state_next = S_UP_CTR;
            end

            S_UP_CTR:
            begin
                if (start_reg < PRW'(m_reg))
                begin
                    x0_next    = '0;
                    f_next     = '0;
                    state_next = S_UP_CLAMP;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = start_reg - PRW'(m_reg);
                    div_den    = PRW'({m_reg, 1'b0});
                    state_next = S_UP_W;
                end
            end

            S_UP_W:
            begin
                if (div_done)
                begin
                    if (div_quo > PRW'(n_reg - XW'(1)))
                    begin
                        x0_next = n_reg - XW'(1);
                        f_next  = '0;
                    end
                    else
                    begin
                        x0_next = XW'(div_quo);
                        f_next  = DW'(div_rem);
                    end
                    state_next = S_UP_CLAMP;
                end
            end

            S_UP_CLAMP:
            begin
                x1_next = (x0_reg + XW'(1) > n_reg - XW'(1)) ? n_reg - XW'(1)
                                                             : x0_reg + XW'(1);
                state_next = S_UP_RD0;
            end

            S_UP_RD0:
            begin
                rd_addr    = x0_reg[AW-1:0];
                state_next = S_UP_RD1;
            end

            S_UP_RD1:
            begin
                rd_addr    = x1_reg[AW-1:0];
                w0_next    = rdata_reg;
                state_next = S_UP_GOT1;
            end

            S_UP_GOT1:
            begin
                w1_next    = rdata_reg;
                den_next   = DW'({m_reg, 1'b0});
                state_next = S_CH_MUL;
            end

            // per channel: form the numerator, then round by division
            S_CH_MUL:
            begin
                if ({1'b0, ch_reg} >= nch_reg)
                    state_next = S_FINISH;
                else
                begin
                    if (up_reg)
                        num_next = PRW'(b0) * PRW'(den_reg - f_reg)
                                 + PRW'(b1) * PRW'(f_reg);
                    else
                        num_next = PRW'(acc_reg[ch_reg]);
                    state_next = S_CH_DIV;
                end
            end

            S_CH_DIV:
            begin
                div_start  = 1'b1;
                div_num    = {num_reg[PRW-2:0], 1'b0} + PRW'(den_reg);
                div_den    = PRW'({den_reg, 1'b0});
                state_next = S_CH_W;
            end

            S_CH_W:
            begin
                if (div_done)
                begin
                    res_next[ch_reg] = (div_quo > PRW'(255)) ? 8'hFF
                                                            : div_quo[lab_pkg::CH_W-1:0];
                    if (ch_reg == 2'd3)
                        state_next = S_FINISH;
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = S_CH_MUL;
                    end
                end
            end

            // hand the word to the result register once it is free
            S_FINISH:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    oidx_next   = idx_reg;
                    ochan_next  = res_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // line store: write on load, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[AW'(req.index)] <= wr_word;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_len_reg  <= lab_pkg::LEN_W'(1);
            out_len_reg <= lab_pkg::LEN_W'(1);
            chans_reg   <= lab_pkg::NCH_W'(lab_pkg::MAX_CHANNELS);
            state_reg   <= S_IDLE;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            in_len_reg  <= in_len_next;
            out_len_reg <= out_len_next;
            chans_reg   <= chans_next;
            state_reg   <= state_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // working payload, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        n_reg     <= n_next;
        m_reg     <= m_next;
        nch_reg   <= nch_next;
        up_reg    <= up_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        lo_reg    <= lo_next;
        x_reg     <= x_next;
        x0_reg    <= x0_next;
        x1_reg    <= x1_next;
        f_reg     <= f_next;
        tot_reg   <= tot_next;
        w0_reg    <= w0_next;
        w1_reg    <= w1_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        ch_reg    <= ch_next;
        acc_reg   <= acc_next;
        res_reg   <= res_next;
        oidx_reg  <= oidx_next;
        ochan_reg <= ochan_next;
    end

    assign rsp.valid        = ovalid_reg;
    assign rsp.result_index = oidx_reg;
    assign rsp.out_chan0    = ochan_reg[0];
    assign rsp.out_chan1    = ochan_reg[1];
    assign rsp.out_chan2    = ochan_reg[2];
    assign rsp.out_chan3    = ochan_reg[3];

endmodule
